// ===== src/cts_pkg.sv =====
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types, codes and field limits for the clock time-set editor.
// ----------------------------------------------------------------------------
package cts_pkg;

  // Button function codes
  localparam logic [1:0] FUNC_NEXT = 2'd0;
  localparam logic [1:0] FUNC_INC  = 2'd1;
  localparam logic [1:0] FUNC_DEC  = 2'd2;

  // Edit mode, one-hot
  typedef enum logic [7:0] {
    MODE_IDLE    = 8'b0000_0001,
    MODE_HOUR    = 8'b0000_0010,
    MODE_MINUTE  = 8'b0000_0100,
    MODE_SECOND  = 8'b0000_1000,
    MODE_YEAR    = 8'b0001_0000,
    MODE_MONTH   = 8'b0010_0000,
    MODE_DAY     = 8'b0100_0000,
    MODE_WEEKDAY = 8'b1000_0000
  } mode_t;

  // Encoded edit mode as seen on the result word
  localparam logic [2:0] EMODE_IDLE    = 3'd0;
  localparam logic [2:0] EMODE_HOUR    = 3'd1;
  localparam logic [2:0] EMODE_MINUTE  = 3'd2;
  localparam logic [2:0] EMODE_SECOND  = 3'd3;
  localparam logic [2:0] EMODE_YEAR    = 3'd4;
  localparam logic [2:0] EMODE_MONTH   = 3'd5;
  localparam logic [2:0] EMODE_DAY     = 3'd6;
  localparam logic [2:0] EMODE_WEEKDAY = 3'd7;

  // Field limits, all held in the 7-bit stepper width
  localparam int unsigned STEP_W = 7;
  localparam logic [STEP_W-1:0] HOUR_MAX    = 7'd23;
  localparam logic [STEP_W-1:0] MINSEC_MAX  = 7'd59;
  localparam logic [STEP_W-1:0] YEAR_MAX    = 7'd99;
  localparam logic [STEP_W-1:0] MONTH_MAX   = 7'd12;
  localparam logic [STEP_W-1:0] WEEKDAY_MAX = 7'd6;
  localparam logic [STEP_W-1:0] ZERO_MIN    = 7'd0;
  localparam logic [STEP_W-1:0] ONE_MIN     = 7'd1;
  localparam logic [6:0]        YEAR_2100   = 7'd100;

  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;

  // Result word
  typedef struct packed {
    logic [2:0] edit_mode;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [2:0] weekday;
    logic       commit;
    logic       tick_enabled;
    logic       beep;
  } result_t;

  // One-hot mode to its 3-bit code
  function automatic logic [2:0] mode_code(mode_t m);
    logic [2:0] c;
    unique case (m)
      MODE_HOUR:    c = EMODE_HOUR;
      MODE_MINUTE:  c = EMODE_MINUTE;
      MODE_SECOND:  c = EMODE_SECOND;
      MODE_YEAR:    c = EMODE_YEAR;
      MODE_MONTH:   c = EMODE_MONTH;
      MODE_DAY:     c = EMODE_DAY;
      MODE_WEEKDAY: c = EMODE_WEEKDAY;
      default:      c = EMODE_IDLE;
    endcase
    return c;
  endfunction

  // Leap year for 2000+yoff; yoff < 128 so only 2000 and 2100 are centuries
  function automatic logic is_leap(logic [6:0] yoff);
    return (yoff[1:0] == 2'b00) && (yoff != YEAR_2100);
  endfunction

  // Days in month; out-of-range months count as 31
  function automatic logic [4:0] month_len(logic [3:0] m, logic [6:0] yoff);
    logic [4:0] len;
    if (m == MONTH_FEB) begin
      len = is_leap(yoff) ? 5'd29 : 5'd28;
    end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

  // Wrapping step up or down within lo..hi
  function automatic logic [STEP_W-1:0] step_val(logic [STEP_W-1:0] v,
                                                 logic [STEP_W-1:0] lo,
                                                 logic [STEP_W-1:0] hi,
                                                 logic              up);
    logic [STEP_W-1:0] r;
    if (up) begin
      r = (v >= hi || v < lo) ? lo : v + 7'd1;
    end else begin
      r = (v <= lo || v > hi) ? hi : v - 7'd1;
    end
    return r;
  endfunction

endpackage

// ===== src/cts_if.sv =====
// ----------------------------------------------------------------------------
// cts_in_if / cts_out_if
// Valid/ready channels carrying button words and result words.
// ----------------------------------------------------------------------------
interface cts_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [4:0] rtc_hour;
  logic [5:0] rtc_minute;
  logic [5:0] rtc_second;
  logic [6:0] rtc_year;
  logic [3:0] rtc_month;
  logic [4:0] rtc_day;
  logic [2:0] rtc_weekday;

  modport source (output valid, func, rtc_hour, rtc_minute, rtc_second, rtc_year,
                  rtc_month, rtc_day, rtc_weekday, input ready);
  modport sink   (input valid, func, rtc_hour, rtc_minute, rtc_second, rtc_year,
                  rtc_month, rtc_day, rtc_weekday, output ready);
endinterface

interface cts_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] edit_mode;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [5:0] second;
  logic [6:0] year;
  logic [3:0] month;
  logic [4:0] day;
  logic [2:0] weekday;
  logic       commit;
  logic       tick_enabled;
  logic       beep;

  modport source (output valid, edit_mode, hour, minute, second, year, month, day,
                  weekday, commit, tick_enabled, beep, input ready);
  modport sink   (input valid, edit_mode, hour, minute, second, year, month, day,
                  weekday, commit, tick_enabled, beep, output ready);
endinterface

// ===== src/clock_time_set_editor.sv =====
// ----------------------------------------------------------------------------
// clock_time_set_editor
// A result word appears in the cycle after its button word is taken.
// Throughput: one word per cycle while out_ch.ready holds; the single
//   output register is refilled in the same cycle it is drained.
// Reset (rst_n, synchronous): mode idle, all held fields zero, output empty.
// ----------------------------------------------------------------------------
module clock_time_set_editor
  import cts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  cts_in_if.sink    in_ch,
  cts_out_if.source out_ch
);

  mode_t       mode_r, mode_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic [5:0]  second_r, second_nxt;
  logic [6:0]  year_r, year_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [2:0]  weekday_r, weekday_nxt;
  logic        commit, beep;
  logic        accept;

  logic        out_valid_r;
  result_t     res_r, res_nxt;

  // stepper operands
  logic [STEP_W-1:0] step_v, step_lo, step_hi, step_res;
  logic              step_up;

  // Input taken whenever the output register is empty or being drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Select the field under edit for the shared stepper
  always_comb begin
    step_v  = ZERO_MIN;
    step_lo = ZERO_MIN;
    step_hi = HOUR_MAX;
    unique case (mode_r)
      MODE_HOUR: begin
        step_v = {2'b00, hour_r};
      end
      MODE_MINUTE: begin
        step_v  = {1'b0, minute_r};
        step_hi = MINSEC_MAX;
      end
      MODE_SECOND: begin
        step_v  = {1'b0, second_r};
        step_hi = MINSEC_MAX;
      end
      MODE_YEAR: begin
        step_v  = year_r;
        step_hi = YEAR_MAX;
      end
      MODE_MONTH: begin
        step_v  = {3'b000, month_r};
        step_lo = ONE_MIN;
        step_hi = MONTH_MAX;
      end
      MODE_DAY: begin
        step_v  = {2'b00, day_r};
        step_lo = ONE_MIN;
        step_hi = {2'b00, month_len(month_r, year_r)};
      end
      MODE_WEEKDAY: begin
        step_v  = {4'b0000, weekday_r};
        step_hi = WEEKDAY_MAX;
      end
      default: begin
        step_v = ZERO_MIN;
      end
    endcase
  end

  assign step_up  = (in_ch.func == FUNC_INC);
  assign step_res = step_val(step_v, step_lo, step_hi, step_up);

  // Next state for an accepted button word
  always_comb begin
    mode_nxt    = mode_r;
    hour_nxt    = hour_r;
    minute_nxt  = minute_r;
    second_nxt  = second_r;
    year_nxt    = year_r;
    month_nxt   = month_r;
    day_nxt     = day_r;
    weekday_nxt = weekday_r;
    commit      = 1'b0;
    beep        = 1'b0;
    unique case (in_ch.func)
      FUNC_NEXT: begin
        beep = 1'b1;
        unique case (mode_r)
          MODE_IDLE: begin
            // capture live RTC and freeze it for editing
            mode_nxt    = MODE_HOUR;
            hour_nxt    = in_ch.rtc_hour;
            minute_nxt  = in_ch.rtc_minute;
            second_nxt  = in_ch.rtc_second;
            year_nxt    = in_ch.rtc_year;
            month_nxt   = in_ch.rtc_month;
            day_nxt     = in_ch.rtc_day;
            weekday_nxt = in_ch.rtc_weekday;
          end
          MODE_HOUR:    mode_nxt = MODE_MINUTE;
          MODE_MINUTE:  mode_nxt = MODE_SECOND;
          MODE_SECOND:  mode_nxt = MODE_YEAR;
          MODE_YEAR:    mode_nxt = MODE_MONTH;
          MODE_MONTH:   mode_nxt = MODE_DAY;
          MODE_DAY:     mode_nxt = MODE_WEEKDAY;
          default: begin
            // leaving weekday: write back and restart ticking
            mode_nxt = MODE_IDLE;
            commit   = 1'b1;
          end
        endcase
      end
      FUNC_INC, FUNC_DEC: begin
        if (mode_r != MODE_IDLE) begin
          beep = 1'b1;
          unique case (mode_r)
            MODE_HOUR:    hour_nxt    = step_res[4:0];
            MODE_MINUTE:  minute_nxt  = step_res[5:0];
            MODE_SECOND:  second_nxt  = step_res[5:0];
            MODE_YEAR:    year_nxt    = step_res;
            MODE_MONTH:   month_nxt   = step_res[3:0];
            MODE_DAY:     day_nxt     = step_res[4:0];
            default:      weekday_nxt = step_res[2:0];
          endcase
        end
      end
      default: begin
        // unused code, ignored
        beep = 1'b0;
      end
    endcase
  end

  // Result word from the updated state
  always_comb begin
    res_nxt.edit_mode    = mode_code(mode_nxt);
    res_nxt.hour         = hour_nxt;
    res_nxt.minute       = minute_nxt;
    res_nxt.second       = second_nxt;
    res_nxt.year         = year_nxt;
    res_nxt.month        = month_nxt;
    res_nxt.day          = day_nxt;
    res_nxt.weekday      = weekday_nxt;
    res_nxt.commit       = commit;
    res_nxt.tick_enabled = (mode_nxt == MODE_IDLE);
    res_nxt.beep         = beep;
  end

  // Edit state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      hour_r    <= '0;
      minute_r  <= '0;
      second_r  <= '0;
      year_r    <= '0;
      month_r   <= '0;
      day_r     <= '0;
      weekday_r <= '0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      hour_r    <= hour_nxt;
      minute_r  <= minute_nxt;
      second_r  <= second_nxt;
      year_r    <= year_nxt;
      month_r   <= month_nxt;
      day_r     <= day_nxt;
      weekday_r <= weekday_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.edit_mode    = res_r.edit_mode;
  assign out_ch.hour         = res_r.hour;
  assign out_ch.minute       = res_r.minute;
  assign out_ch.second       = res_r.second;
  assign out_ch.year         = res_r.year;
  assign out_ch.month        = res_r.month;
  assign out_ch.day          = res_r.day;
  assign out_ch.weekday      = res_r.weekday;
  assign out_ch.commit       = res_r.commit;
  assign out_ch.tick_enabled = res_r.tick_enabled;
  assign out_ch.beep         = res_r.beep;

endmodule
